>>> sv/ubjs_pkg.sv
// Package for the UBJSON token scanner: token kinds, parse phases, marker bytes,
// scanner state and token structs, and marker decode functions. No dependencies.
`default_nettype none

package ubjs_pkg;

    localparam int unsigned KIND_W   = 5;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned REMAIN_W = 63;
    localparam int unsigned LEFT_W   = 4;

    typedef logic [2:0]          phase_t;
    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [7:0]          byte_t;
    typedef logic [LEFT_W-1:0]   left_t;

    // Parse phases
    localparam phase_t PH_MARKER  = 3'd0;
    localparam phase_t PH_NUMBER  = 3'd1;
    localparam phase_t PH_LENMARK = 3'd2;
    localparam phase_t PH_LENGTH  = 3'd3;
    localparam phase_t PH_PAYLOAD = 3'd4;

    // Token kinds
    localparam kind_t K_EOF       = 5'd0;
    localparam kind_t K_ERROR     = 5'd1;
    localparam kind_t K_NULL      = 5'd2;
    localparam kind_t K_TRUE      = 5'd3;
    localparam kind_t K_FALSE     = 5'd4;
    localparam kind_t K_INT8      = 5'd5;
    localparam kind_t K_INT16     = 5'd6;
    localparam kind_t K_INT32     = 5'd7;
    localparam kind_t K_INT64     = 5'd8;
    localparam kind_t K_F32       = 5'd9;
    localparam kind_t K_F64       = 5'd10;
    localparam kind_t K_STRHDR    = 5'd11;
    localparam kind_t K_STRBYTE   = 5'd12;
    localparam kind_t K_OBJ_BEGIN = 5'd13;
    localparam kind_t K_OBJ_END   = 5'd14;
    localparam kind_t K_ARR_BEGIN = 5'd15;
    localparam kind_t K_ARR_END   = 5'd16;

    // Marker bytes (ASCII)
    localparam byte_t MK_NULL      = 8'h5A; // 'Z'
    localparam byte_t MK_TRUE      = 8'h54; // 'T'
    localparam byte_t MK_FALSE     = 8'h46; // 'F'
    localparam byte_t MK_NOOP      = 8'h4E; // 'N'
    localparam byte_t MK_INT8      = 8'h42; // 'B'
    localparam byte_t MK_INT16     = 8'h69; // 'i'
    localparam byte_t MK_INT32     = 8'h49; // 'I'
    localparam byte_t MK_INT64     = 8'h4C; // 'L'
    localparam byte_t MK_F32       = 8'h64; // 'd'
    localparam byte_t MK_F64       = 8'h44; // 'D'
    localparam byte_t MK_STRING    = 8'h73; // 's'
    localparam byte_t MK_OBJ_BEGIN = 8'h7B; // '{'
    localparam byte_t MK_OBJ_END   = 8'h7D; // '}'
    localparam byte_t MK_ARR_BEGIN = 8'h5B; // '['
    localparam byte_t MK_ARR_END   = 8'h5D; // ']'

    typedef struct packed {
        phase_t                phase;
        kind_t                 pending_kind;
        left_t                 bytes_left;
        logic [VALUE_W-1:0]    assembly;
        logic [REMAIN_W-1:0]   payload_remaining;
        logic                  error_sticky;
    } scan_state_t;

    typedef struct packed {
        kind_t                 kind;
        logic [VALUE_W-1:0]    value;
        logic                  last;
    } token_t;

    // Byte count of a numeric kind, zero for anything else
    function automatic left_t size_of_kind(input kind_t kind);
        left_t n;
        case (kind)
            K_INT8:  n = 4'd1;
            K_INT16: n = 4'd2;
            K_INT32: n = 4'd4;
            K_INT64: n = 4'd8;
            K_F32:   n = 4'd4;
            K_F64:   n = 4'd8;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // Integer kind of an integer marker, K_EOF when the byte is not one
    function automatic kind_t int_kind_of(input byte_t b);
        kind_t k;
        case (b)
            MK_INT8:  k = K_INT8;
            MK_INT16: k = K_INT16;
            MK_INT32: k = K_INT32;
            MK_INT64: k = K_INT64;
            default:  k = K_EOF;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> sv/ubjs_if.sv
// Valid/ready channel interfaces for the UBJSON token scanner:
// byte input channel and token output channel. Depends on ubjs_pkg.
`default_nettype none

interface ubjs_byte_if
    import ubjs_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  is_end;

    modport source (output valid, output data_byte, output is_end, input ready);
    modport sink   (input valid, input data_byte, input is_end, output ready);
endinterface

interface ubjs_tok_if
    import ubjs_pkg::*;
();
    logic               valid;
    logic               ready;
    kind_t              token_kind;
    logic [VALUE_W-1:0] token_value;
    logic               last_of_string;

    modport source (output valid, output token_kind, output token_value,
                    output last_of_string, input ready);
    modport sink   (input valid, input token_kind, input token_value,
                    input last_of_string, output ready);
endinterface

`default_nettype wire

>>> sv/ubjs_step.sv
// Single-item decode step of the UBJSON token scanner: next scanner state and
// the optional token for one byte or end item. Depends on ubjs_pkg.
`default_nettype none

module ubjs_step
    import ubjs_pkg::*;
(
    input  scan_state_t st,
    input  byte_t       data_byte,
    input  logic        is_end,
    output scan_state_t st_next,
    output logic        emit,
    output token_t      tok
);

    logic [VALUE_W-1:0]  assembled;
    left_t               left_dec;
    logic [REMAIN_W-1:0] remain_dec;
    kind_t               ikind;
    logic                len_negative;

    assign assembled  = {st.assembly[VALUE_W-9:0], data_byte};
    assign left_dec   = (st.bytes_left != '0) ? st.bytes_left - left_t'(1) : st.bytes_left;
    assign remain_dec = (st.payload_remaining != '0)
                        ? st.payload_remaining - REMAIN_W'(1) : st.payload_remaining;
    assign ikind      = int_kind_of(data_byte);

    // Sign bit of the length at its own width
    always_comb begin
        case (st.pending_kind)
            K_INT8:  len_negative = assembled[7];
            K_INT16: len_negative = assembled[15];
            K_INT32: len_negative = assembled[31];
            K_INT64: len_negative = assembled[63];
            default: len_negative = 1'b1;
        endcase
    end

    always_comb begin
        st_next   = st;
        emit      = 1'b0;
        tok.kind  = K_EOF;
        tok.value = '0;
        tok.last  = 1'b0;

        if (st.error_sticky) begin
            emit     = 1'b1;
            tok.kind = K_ERROR;
        end else if (is_end) begin
            st_next.phase             = PH_MARKER;
            st_next.pending_kind      = K_EOF;
            st_next.bytes_left        = '0;
            st_next.assembly          = '0;
            st_next.payload_remaining = '0;
            emit                      = 1'b1;
            tok.kind                  = K_EOF;
        end else begin
            unique case (st.phase)
                PH_NUMBER: begin
                    st_next.assembly   = assembled;
                    st_next.bytes_left = left_dec;
                    if (left_dec == '0) begin
                        st_next.phase = PH_MARKER;
                        emit          = 1'b1;
                        tok.kind      = st.pending_kind;
                        tok.value     = assembled;
                    end
                end
                PH_LENMARK: begin
                    if (ikind == K_EOF) begin
                        st_next.error_sticky = 1'b1;
                        st_next.phase        = PH_MARKER;
                        st_next.bytes_left   = '0;
                        emit                 = 1'b1;
                        tok.kind             = K_ERROR;
                    end else begin
                        st_next.pending_kind = ikind;
                        st_next.bytes_left   = size_of_kind(ikind);
                        st_next.assembly     = '0;
                        st_next.phase        = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    st_next.assembly   = assembled;
                    st_next.bytes_left = left_dec;
                    if (left_dec == '0) begin
                        emit = 1'b1;
                        if (len_negative) begin
                            st_next.error_sticky = 1'b1;
                            st_next.phase        = PH_MARKER;
                            st_next.bytes_left   = '0;
                            tok.kind             = K_ERROR;
                        end else if (assembled == '0) begin
                            // empty string: header closes it
                            st_next.phase = PH_MARKER;
                            tok.kind      = K_STRHDR;
                            tok.last      = 1'b1;
                        end else begin
                            st_next.payload_remaining = assembled[REMAIN_W-1:0];
                            st_next.phase             = PH_PAYLOAD;
                            tok.kind                  = K_STRHDR;
                            tok.value                 = {1'b0, assembled[REMAIN_W-1:0]};
                        end
                    end
                end
                PH_PAYLOAD: begin
                    st_next.payload_remaining = remain_dec;
                    emit                      = 1'b1;
                    tok.kind                  = K_STRBYTE;
                    tok.value                 = {{(VALUE_W-8){1'b0}}, data_byte};
                    if (remain_dec == '0) begin
                        st_next.phase = PH_MARKER;
                        tok.last      = 1'b1;
                    end
                end
                default: begin
                    // expecting marker; unused phase codes land here too
                    st_next.phase = PH_MARKER;
                    unique case (data_byte)
                        MK_NULL:      begin emit = 1'b1; tok.kind = K_NULL;      end
                        MK_TRUE:      begin emit = 1'b1; tok.kind = K_TRUE;      end
                        MK_FALSE:     begin emit = 1'b1; tok.kind = K_FALSE;     end
                        MK_NOOP:      emit = 1'b0;
                        MK_OBJ_BEGIN: begin emit = 1'b1; tok.kind = K_OBJ_BEGIN; end
                        MK_OBJ_END:   begin emit = 1'b1; tok.kind = K_OBJ_END;   end
                        MK_ARR_BEGIN: begin emit = 1'b1; tok.kind = K_ARR_BEGIN; end
                        MK_ARR_END:   begin emit = 1'b1; tok.kind = K_ARR_END;   end
                        MK_F32: begin
                            st_next.pending_kind = K_F32;
                            st_next.bytes_left   = size_of_kind(K_F32);
                            st_next.assembly     = '0;
                            st_next.phase        = PH_NUMBER;
                        end
                        MK_F64: begin
                            st_next.pending_kind = K_F64;
                            st_next.bytes_left   = size_of_kind(K_F64);
                            st_next.assembly     = '0;
                            st_next.phase        = PH_NUMBER;
                        end
                        MK_STRING: st_next.phase = PH_LENMARK;
                        default: begin
                            if (ikind == K_EOF) begin
                                st_next.error_sticky = 1'b1;
                                st_next.bytes_left   = '0;
                                emit                 = 1'b1;
                                tok.kind             = K_ERROR;
                            end else begin
                                st_next.pending_kind = ikind;
                                st_next.bytes_left   = size_of_kind(ikind);
                                st_next.assembly     = '0;
                                st_next.phase        = PH_NUMBER;
                            end
                        end
                    endcase
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/ubjs_out_stage.sv
// Token result register of the UBJSON token scanner, driving the output
// channel. Depends on ubjs_pkg and ubjs_tok_if.
`default_nettype none

module ubjs_out_stage
    import ubjs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  token_t            tok,
    output logic              advance,
    ubjs_tok_if.source        token_out
);

    logic   valid_reg;
    token_t tok_reg;

    // Register may take a new token when empty or being drained
    assign advance = !valid_reg || token_out.ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk) begin
        if (advance && load) begin
            tok_reg <= tok;
        end
    end

    assign token_out.valid          = valid_reg;
    assign token_out.token_kind     = tok_reg.kind;
    assign token_out.token_value    = tok_reg.value;
    assign token_out.last_of_string = tok_reg.last;

endmodule

`default_nettype wire

>>> sv/ubjson_token_scanner_core.sv
// Top level of the UBJSON token scanner: input register, scanner state,
// decode step and token register. Depends on ubjs_pkg, ubjs_if, ubjs_step, ubjs_out_stage.
`default_nettype none

// Channel     Dir  Payload                                         Accepted when
// ---------   ---  ----------------------------------------------  --------------------
// byte_in     in   data_byte[7:0], is_end                          valid && ready
// token_out   out  token_kind[4:0], token_value[63:0], last_of_string  valid && ready
//
// Rate: one item per cycle sustained while token_out is not stalled; a byte is
//   taken into the input register, its token is then loaded into the token
//   register, and the token leaves from there when token_out is ready.
// Throughput is set by the single decode step between the input register and
//   the token register; the scanner state updates once per item.
// Reset: rst_n clears the phase, counters and sticky error at once; no sweep.
// Stalls: while token_out is stalled with a token held, the input register
//   still takes one item if empty, then byte_in drops ready.

module ubjson_token_scanner_core
    import ubjs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ubjs_byte_if.sink   byte_in,
    ubjs_tok_if.source  token_out
);

    // Input register
    logic        in_valid_reg;
    byte_t       in_byte_reg;
    logic        in_end_reg;

    // Scanner state
    scan_state_t state_reg;
    scan_state_t state_next;

    logic        advance;
    logic        fire;
    logic        emit;
    token_t      tok;

    // Hold the input item until the token register can take its result
    assign fire          = in_valid_reg && advance;
    assign byte_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (byte_in.ready) begin
            in_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (byte_in.valid && byte_in.ready) begin
            in_byte_reg <= byte_in.data_byte;
            in_end_reg  <= byte_in.is_end;
        end
    end

    // Advance the scanner state once per processed item
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg.phase             <= PH_MARKER;
            state_reg.pending_kind      <= K_EOF;
            state_reg.bytes_left        <= '0;
            state_reg.assembly          <= '0;
            state_reg.payload_remaining <= '0;
            state_reg.error_sticky      <= 1'b0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    ubjs_step u_step (
        .st        (state_reg),
        .data_byte (in_byte_reg),
        .is_end    (in_end_reg),
        .st_next   (state_next),
        .emit      (emit),
        .tok       (tok)
    );

    // Load the token register only for items that produce a token
    ubjs_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && emit),
        .tok       (tok),
        .advance   (advance),
        .token_out (token_out)
    );

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for ubjson_token_scanner_core: directed rows, then random UBJSON
// streams, checked against a cycle-free scanner model. Depends on ubjs_pkg and ubjs_if.

module testbench;

    import ubjs_pkg::*;

    // No-accept limit. The slowest correct run stalls for a short random burst
    // on either side plus the pass through the input and token registers; STALL_LIMIT is far beyond it.
    localparam int STALL_LIMIT = 1000;
    // Window of cycles with no idling on either side.
    localparam int CALM_FROM   = 700;
    localparam int CALM_TO     = 1100;
    localparam int RANDOM_ITEMS = 1000;
    localparam int TAIL_CYCLES  = 10;

    // One stream item. Rows marked fixed carry their token typed in by hand;
    // the others take the scanner model's answer.
    typedef struct packed {
        logic   is_end;
        byte_t  data;
        bit     fixed;
        bit     has_token;
        token_t tok;
    } stream_item_t;

    localparam int DIRECTED_ROWS = 25;
    localparam stream_item_t DIRECTED [DIRECTED_ROWS] = '{
        // Plain markers straight after reset
        '{1'b0, MK_NULL,      1'b1, 1'b1, '{K_NULL,      64'd0, 1'b0}},
        '{1'b0, MK_TRUE,      1'b1, 1'b1, '{K_TRUE,      64'd0, 1'b0}},
        '{1'b0, MK_FALSE,     1'b1, 1'b1, '{K_FALSE,     64'd0, 1'b0}},
        '{1'b0, MK_NOOP,      1'b1, 1'b0, '{K_EOF,       64'd0, 1'b0}},
        '{1'b0, MK_OBJ_BEGIN, 1'b1, 1'b1, '{K_OBJ_BEGIN, 64'd0, 1'b0}},
        '{1'b0, MK_OBJ_END,   1'b1, 1'b1, '{K_OBJ_END,   64'd0, 1'b0}},
        '{1'b0, MK_ARR_BEGIN, 1'b1, 1'b1, '{K_ARR_BEGIN, 64'd0, 1'b0}},
        '{1'b0, MK_ARR_END,   1'b1, 1'b1, '{K_ARR_END,   64'd0, 1'b0}},
        // int8 at its top byte
        '{1'b0, MK_INT8,      1'b1, 1'b0, '{K_EOF,       64'd0, 1'b0}},
        '{1'b0, 8'hFF,        1'b1, 1'b1, '{K_INT8,      64'hFF, 1'b0}},
        // int16 with only the sign bit set
        '{1'b0, MK_INT16,     1'b1, 1'b0, '{K_EOF,       64'd0, 1'b0}},
        '{1'b0, 8'h80,        1'b1, 1'b0, '{K_EOF,       64'd0, 1'b0}},
        '{1'b0, 8'h00,        1'b1, 1'b1, '{K_INT16,     64'h8000, 1'b0}},
        // End in the middle of an int64, then an end on its own
        '{1'b0, MK_INT64,     1'b1, 1'b0, '{K_EOF,       64'd0, 1'b0}},
        '{1'b0, 8'hAA,        1'b1, 1'b0, '{K_EOF,       64'd0, 1'b0}},
        '{1'b1, 8'h00,        1'b1, 1'b1, '{K_EOF,       64'd0, 1'b0}},
        '{1'b1, 8'hFF,        1'b1, 1'b1, '{K_EOF,       64'd0, 1'b0}},
        // Empty string: header alone, marked last
        '{1'b0, MK_STRING,    1'b1, 1'b0, '{K_EOF,       64'd0, 1'b0}},
        '{1'b0, MK_INT8,      1'b1, 1'b0, '{K_EOF,       64'd0, 1'b0}},
        '{1'b0, 8'h00,        1'b1, 1'b1, '{K_STRHDR,    64'd0, 1'b1}},
        // One-byte string with an int16 length; header from the model
        '{1'b0, MK_STRING,    1'b0, 1'b0, '{K_EOF,       64'd0, 1'b0}},
        '{1'b0, MK_INT16,     1'b0, 1'b0, '{K_EOF,       64'd0, 1'b0}},
        '{1'b0, 8'h00,        1'b0, 1'b0, '{K_EOF,       64'd0, 1'b0}},
        '{1'b0, 8'h01,        1'b0, 1'b0, '{K_EOF,       64'd0, 1'b0}},
        '{1'b0, 8'h00,        1'b1, 1'b1, '{K_STRBYTE,   64'd0, 1'b1}}
    };

    logic clk;
    logic rst_n;

    ubjs_byte_if byte_in ();
    ubjs_tok_if  token_out ();

    ubjson_token_scanner_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .token_out (token_out)
    );

    stream_item_t byte_stream [$];
    stream_item_t segment [$];
    token_t       pending_tokens [$];

    int taken        = 0;
    int cycle_count  = 0;
    int stall_cycles = 0;
    int failures     = 0;

    // Scanner model state
    phase_t              sc_phase;
    kind_t               sc_pend;
    left_t               sc_left;
    logic [VALUE_W-1:0]  sc_acc;
    logic [REMAIN_W-1:0] sc_remain;
    logic                sc_err;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------

    // Integer kind named by a length marker, K_EOF for any other byte
    function automatic kind_t length_kind(input byte_t b);
        case (b)
            MK_INT8:  return K_INT8;
            MK_INT16: return K_INT16;
            MK_INT32: return K_INT32;
            MK_INT64: return K_INT64;
            default:  return K_EOF;
        endcase
    endfunction

    function automatic int unsigned kind_bytes(input kind_t k);
        case (k)
            K_INT8:         return 1;
            K_INT16:        return 2;
            K_INT32, K_F32: return 4;
            K_INT64, K_F64: return 8;
            default:        return 0;
        endcase
    endfunction

    function automatic bit is_marker(input byte_t b);
        case (b)
            MK_NULL, MK_TRUE, MK_FALSE, MK_NOOP, MK_INT8, MK_INT16, MK_INT32,
            MK_INT64, MK_F32, MK_F64, MK_STRING, MK_OBJ_BEGIN, MK_OBJ_END,
            MK_ARR_BEGIN, MK_ARR_END: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic reset_scanner();
        sc_phase  = PH_MARKER;
        sc_pend   = K_EOF;
        sc_left   = '0;
        sc_acc    = '0;
        sc_remain = '0;
        sc_err    = 1'b0;
    endtask

    task automatic begin_collect(input kind_t k, input phase_t ph);
        sc_pend  = k;
        sc_left  = left_t'(kind_bytes(k));
        sc_acc   = '0;
        sc_phase = ph;
    endtask

    // Advance the model by one item; has is set when the item yields a token.
    task automatic scan_item(input byte_t b, input logic e, output bit has, output token_t tok);
        kind_t       k;
        int unsigned nbits;
        bit          bad;
        has = 1'b0;
        bad = 1'b0;
        tok = '0;
        if (sc_err)
        begin
            // Sticky error: every item gives an error, ends included
            has = 1'b1;
            tok.kind = K_ERROR;
        end
        else if (e)
        begin
            // End drops whatever is half collected
            sc_phase  = PH_MARKER;
            sc_pend   = K_EOF;
            sc_left   = '0;
            sc_acc    = '0;
            sc_remain = '0;
            has = 1'b1;
            tok.kind = K_EOF;
        end
        else
        begin
            if (sc_phase > PH_PAYLOAD)
                sc_phase = PH_MARKER;
            case (sc_phase)
                PH_MARKER:
                begin
                    case (b)
                        MK_NULL:      begin has = 1'b1; tok.kind = K_NULL;      end
                        MK_TRUE:      begin has = 1'b1; tok.kind = K_TRUE;      end
                        MK_FALSE:     begin has = 1'b1; tok.kind = K_FALSE;     end
                        MK_OBJ_BEGIN: begin has = 1'b1; tok.kind = K_OBJ_BEGIN; end
                        MK_OBJ_END:   begin has = 1'b1; tok.kind = K_OBJ_END;   end
                        MK_ARR_BEGIN: begin has = 1'b1; tok.kind = K_ARR_BEGIN; end
                        MK_ARR_END:   begin has = 1'b1; tok.kind = K_ARR_END;   end
                        MK_NOOP:      ;
                        MK_F32:       begin_collect(K_F32, PH_NUMBER);
                        MK_F64:       begin_collect(K_F64, PH_NUMBER);
                        MK_STRING:    sc_phase = PH_LENMARK;
                        default:
                        begin
                            k = length_kind(b);
                            if (k == K_EOF)
                                bad = 1'b1;
                            else
                                begin_collect(k, PH_NUMBER);
                        end
                    endcase
                end
                PH_NUMBER:
                begin
                    sc_acc = {sc_acc[VALUE_W-9:0], b};
                    if (sc_left != 0)
                        sc_left = sc_left - 1'b1;
                    if (sc_left == 0)
                    begin
                        sc_phase  = PH_MARKER;
                        has       = 1'b1;
                        tok.kind  = sc_pend;
                        tok.value = sc_acc;
                    end
                end
                PH_LENMARK:
                begin
                    k = length_kind(b);
                    if (k == K_EOF)
                        bad = 1'b1;
                    else
                        begin_collect(k, PH_LENGTH);
                end
                PH_LENGTH:
                begin
                    sc_acc = {sc_acc[VALUE_W-9:0], b};
                    if (sc_left != 0)
                        sc_left = sc_left - 1'b1;
                    if (sc_left == 0)
                    begin
                        nbits = 8 * kind_bytes(sc_pend);
                        // Length is signed at its own width
                        if (nbits == 0 || sc_acc[nbits-1])
                            bad = 1'b1;
                        else if (sc_acc == 0)
                        begin
                            sc_phase = PH_MARKER;
                            has      = 1'b1;
                            tok.kind = K_STRHDR;
                            tok.last = 1'b1;
                        end
                        else
                        begin
                            sc_remain = sc_acc[REMAIN_W-1:0];
                            sc_phase  = PH_PAYLOAD;
                            has       = 1'b1;
                            tok.kind  = K_STRHDR;
                            tok.value = {1'b0, sc_remain};
                        end
                    end
                end
                default:
                begin
                    if (sc_remain != 0)
                        sc_remain = sc_remain - 1'b1;
                    has       = 1'b1;
                    tok.kind  = K_STRBYTE;
                    tok.value = {56'd0, b};
                    if (sc_remain == 0)
                    begin
                        sc_phase = PH_MARKER;
                        tok.last = 1'b1;
                    end
                end
            endcase
        end
        if (bad)
        begin
            sc_err   = 1'b1;
            sc_phase = PH_MARKER;
            sc_left  = '0;
            has      = 1'b1;
            tok      = '0;
            tok.kind = K_ERROR;
        end
    endtask

    // ------------------------------------------------------------------
    // Stream builders
    // ------------------------------------------------------------------

    task automatic add_byte(input byte_t b);
        stream_item_t it;
        it = '0;
        it.data = b;
        segment.push_back(it);
    endtask

    task automatic add_end();
        stream_item_t it;
        it = '0;
        it.is_end = 1'b1;
        it.data   = byte_t'($urandom);
        segment.push_back(it);
    endtask

    // Number body of n bytes, biased toward the corners
    task automatic add_number_bytes(input int n);
        int pick;
        pick = $urandom_range(9);
        for (int i = 0; i < n; i++)
        begin
            case (pick)
                0:       add_byte(8'h00);
                1:       add_byte(8'hFF);
                2:       add_byte(i == 0 ? 8'h80 : 8'h00);
                3:       add_byte(i == 0 ? 8'h7F : 8'hFF);
                default: add_byte(byte_t'($urandom));
            endcase
        end
    endtask

    task automatic add_length(input int n, input logic [63:0] len);
        for (int i = n - 1; i >= 0; i--)
            add_byte(byte_t'(len >> (8 * i)));
    endtask

    task automatic pick_length_marker(output byte_t mk, output int n);
        case ($urandom_range(3))
            0:       begin mk = MK_INT8;  n = 1; end
            1:       begin mk = MK_INT16; n = 2; end
            2:       begin mk = MK_INT32; n = 4; end
            default: begin mk = MK_INT64; n = 8; end
        endcase
    endtask

    task automatic build_simple();
        case ($urandom_range(7))
            0:       add_byte(MK_NULL);
            1:       add_byte(MK_TRUE);
            2:       add_byte(MK_FALSE);
            3:       add_byte(MK_NOOP);
            4:       add_byte(MK_OBJ_BEGIN);
            5:       add_byte(MK_OBJ_END);
            6:       add_byte(MK_ARR_BEGIN);
            default: add_byte(MK_ARR_END);
        endcase
    endtask

    task automatic build_number();
        case ($urandom_range(5))
            0:       begin add_byte(MK_INT8);  add_number_bytes(1); end
            1:       begin add_byte(MK_INT16); add_number_bytes(2); end
            2:       begin add_byte(MK_INT32); add_number_bytes(4); end
            3:       begin add_byte(MK_INT64); add_number_bytes(8); end
            4:       begin add_byte(MK_F32);   add_number_bytes(4); end
            default: begin add_byte(MK_F64);   add_number_bytes(8); end
        endcase
    endtask

    // Complete string; lengths stay small, with a rare full int8 length
    task automatic build_string();
        byte_t       mk;
        int          n;
        int          pick;
        logic [63:0] len;
        pick_length_marker(mk, n);
        pick = $urandom_range(99);
        if (pick < 70)
            len = $urandom_range(6);
        else if (pick < 92)
            len = $urandom_range(40, 7);
        else
            len = 127;
        add_byte(MK_STRING);
        add_byte(mk);
        add_length(n, len);
        for (int i = 0; i < len; i++)
            add_byte(byte_t'($urandom));
    endtask

    // String with the largest positive length at its width, cut short by an end
    task automatic build_open_string();
        byte_t mk;
        int    n;
        pick_length_marker(mk, n);
        add_byte(MK_STRING);
        add_byte(mk);
        add_byte(8'h7F);
        for (int i = 1; i < n; i++)
            add_byte(8'hFF);
        repeat ($urandom_range(5))
            add_byte(byte_t'($urandom));
        add_end();
    endtask

    task automatic append_segment(input int keep);
        for (int i = 0; i < keep; i++)
            byte_stream.push_back(segment[i]);
        segment.delete();
    endtask

    // Error tail: one of the three error causes, then items under the sticky error
    task automatic build_error_tail();
        byte_t b;
        byte_t mk;
        int    n;
        case ($urandom_range(2))
            0:
            begin
                // Unknown marker
                do b = byte_t'($urandom); while (is_marker(b));
                add_byte(b);
            end
            1:
            begin
                // Bad length marker after a string marker
                do b = byte_t'($urandom); while (length_kind(b) != K_EOF);
                add_byte(MK_STRING);
                add_byte(b);
            end
            default:
            begin
                // Negative length
                pick_length_marker(mk, n);
                add_byte(MK_STRING);
                add_byte(mk);
                add_byte(byte_t'($urandom_range(255, 128)));
                for (int i = 1; i < n; i++)
                    add_byte(byte_t'($urandom));
            end
        endcase
        repeat (20)
        begin
            if ($urandom_range(1))
                add_end();
            else
                add_byte(byte_t'($urandom));
        end
        append_segment(segment.size());
    endtask

    task automatic build_stream();
        int pick;
        for (int i = 0; i < DIRECTED_ROWS; i++)
            byte_stream.push_back(DIRECTED[i]);
        while (byte_stream.size() < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 22)
            begin
                build_simple();
                append_segment(segment.size());
            end
            else if (pick < 52)
            begin
                build_number();
                append_segment(segment.size());
            end
            else if (pick < 78)
            begin
                build_string();
                append_segment(segment.size());
            end
            else if (pick < 90)
            begin
                // Broken token: cut a well-formed one and close with an end
                if ($urandom_range(1))
                    build_number();
                else
                    build_string();
                append_segment($urandom_range(segment.size() - 1, 1));
                add_end();
                append_segment(1);
            end
            else if (pick < 95)
            begin
                build_open_string();
                append_segment(segment.size());
            end
            else
            begin
                add_end();
                append_segment(1);
            end
        end
        build_error_tail();
    endtask

    // ------------------------------------------------------------------
    // Drive: inputs change on the falling edge
    // ------------------------------------------------------------------

    initial
    begin : drive
        bit calm;
        bit send;
        int offered;
        offered           = -1;
        byte_in.valid     = 1'b0;
        byte_in.data_byte = '0;
        byte_in.is_end    = 1'b0;
        token_out.ready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);
            // Hold an offered item until it is taken
            if (byte_in.valid && offered == taken)
                send = 1'b1;
            else
                send = (taken < byte_stream.size()) && (calm || $urandom_range(99) >= 29);
            byte_in.valid <= send;
            if (send)
            begin
                offered = taken;
                byte_in.data_byte <= byte_stream[taken].data;
                byte_in.is_end    <= byte_stream[taken].is_end;
            end
            token_out.ready <= calm || $urandom_range(99) >= 29;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : monitor
        bit           has;
        token_t       tok;
        token_t       want;
        stream_item_t it;
        bit           moved;
        if (rst_n)
        begin
            moved = 1'b0;
            cycle_count++;
            if (byte_in.valid && byte_in.ready)
            begin
                moved = 1'b1;
                it = byte_stream[taken];
                scan_item(byte_in.data_byte, byte_in.is_end, has, tok);
                // Hand-typed rows override the model
                if (it.fixed)
                begin
                    has = it.has_token;
                    tok = it.tok;
                end
                if (has)
                    pending_tokens.push_back(tok);
                taken++;
            end
            if (token_out.valid && token_out.ready)
            begin
                moved = 1'b1;
                if (pending_tokens.size() == 0)
                begin
                    $error("token_kind %0d arrived with no token expected",
                           token_out.token_kind);
                    failures++;
                end
                else
                begin
                    want = pending_tokens.pop_front();
                    if (token_out.token_kind !== want.kind)
                    begin
                        $error("token_kind: expected %0d, got %0d",
                               want.kind, token_out.token_kind);
                        failures++;
                    end
                    if (token_out.token_value !== want.value)
                    begin
                        $error("token_value: expected 0x%016h, got 0x%016h",
                               want.value, token_out.token_value);
                        failures++;
                    end
                    if (token_out.last_of_string !== want.last)
                    begin
                        $error("last_of_string: expected %0b, got %0b",
                               want.last, token_out.last_of_string);
                        failures++;
                    end
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
        end
    end

    // Watchdog: no handshake on either side for too long
    initial
    begin
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n = 1'b0;
        reset_scanner();
        build_stream();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Hold until every item is taken and every token has come back
        while (taken < byte_stream.size())
            @(posedge clk);
        while (pending_tokens.size() != 0)
            @(posedge clk);
        // Let any stray token surface through the two register stages
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_tokens.size() != 0)
        begin
            $error("%0d tokens never arrived", pending_tokens.size());
            failures++;
        end

        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
